>>> hw/rtl/qmna_pkg.sv
// qmna_pkg: shared widths, request and status codes and link types of the
// quad mesh normal accumulator; depends on nothing

package qmna_pkg;

  localparam int MAX_VERTICES_DEF = 4096;

  localparam int REQ_W = 2;
  localparam int IDX_W = 13;
  localparam int POS_W = 24;
  localparam int NRM_W = 24;
  localparam int ST_W  = 2;
  localparam int DIF_W = 25;   // difference of two positions
  localparam int PRD_W = 50;   // product of two differences
  localparam int CRS_W = 51;   // cross product component
  localparam int NQ_W  = 16;   // unit normal component, Q2.14

  localparam logic [IDX_W-1:0] VC_RESET = 13'd4096;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FACE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_IDX = 2'd1;
  localparam logic [ST_W-1:0] ST_DEGEN   = 2'd2;
  localparam logic [ST_W-1:0] ST_SAT     = 2'd3;

  typedef struct packed {
    logic                    start;
    logic signed [CRS_W-1:0] cx;
    logic signed [CRS_W-1:0] cy;
    logic signed [CRS_W-1:0] cz;
  } norm_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_stat_t;

endpackage

>>> hw/rtl/qmna_channels.sv
// qmna channel interfaces: request, result and configuration write channels
// depends on qmna_pkg

interface qmna_in_if;
  import qmna_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [IDX_W-1:0]        corner_a;
  logic [IDX_W-1:0]        corner_b;
  logic [IDX_W-1:0]        corner_c;
  logic [IDX_W-1:0]        corner_d;
  modport source(output valid, req_type, vertex_index, pos_x, pos_y, pos_z,
                 corner_a, corner_b, corner_c, corner_d, input ready);
  modport sink(input valid, req_type, vertex_index, pos_x, pos_y, pos_z,
               corner_a, corner_b, corner_c, corner_d, output ready);
endinterface

interface qmna_out_if;
  import qmna_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic [ST_W-1:0]         status;
  modport source(output valid, normal_x, normal_y, normal_z, status, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, status, output ready);
endinterface

interface qmna_cfg_if;
  import qmna_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> hw/rtl/qmna_normalize.sv
// qmna_normalize: scales a cross product to unit length in Q2.14 using an
// iterative range shift, shared squarer, bit-serial square root and divider
// depends on qmna_pkg

module qmna_normalize (
  input  logic                             clk,
  input  logic                             rst_n,
  input  qmna_pkg::norm_req_t              req,
  output qmna_pkg::norm_stat_t             stat,
  output logic signed [qmna_pkg::NQ_W-1:0] n_x,
  output logic signed [qmna_pkg::NQ_W-1:0] n_y,
  output logic signed [qmna_pkg::NQ_W-1:0] n_z
);
  import qmna_pkg::*;

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DIV   = 6'b010000,
    N_DONE  = 6'b100000
  } nstate_t;

  nstate_t                 nst_r;
  logic [CRS_W-1:0]        m_r [3];
  logic [2:0]              neg_r;
  logic [5:0]              step_r;
  logic [1:0]              k_r;
  logic [59:0]             prod_r;
  logic [61:0]             sq_r;
  logic [61:0]             rad_r;
  logic [62:0]             root_r;
  logic [62:0]             bit_r;
  logic [31:0]             mag_r;
  logic [32:0]             rem_r;
  logic [16:0]             dvd_r;
  logic [16:0]             quo_r;
  logic signed [NQ_W-1:0]  n_r [3];
  logic                    zero_r;

  logic [CRS_W-1:0] top01, top;
  logic [62:0]      sum_rb;
  logic             sq_ge;
  logic [32:0]      trial;
  logic             div_ge;
  logic [16:0]      q_fin;
  logic [15:0]      q_rnd;
  logic [CRS_W-1:0] abs_x, abs_y, abs_z;

  assign abs_x = req.cx[CRS_W-1] ? CRS_W'(-req.cx) : CRS_W'(req.cx);
  assign abs_y = req.cy[CRS_W-1] ? CRS_W'(-req.cy) : CRS_W'(req.cy);
  assign abs_z = req.cz[CRS_W-1] ? CRS_W'(-req.cz) : CRS_W'(req.cz);

  assign top01 = (m_r[0] > m_r[1]) ? m_r[0] : m_r[1];
  assign top   = (top01 > m_r[2]) ? top01 : m_r[2];

  // square root digit step
  assign sum_rb = root_r + bit_r;
  assign sq_ge  = {1'b0, rad_r} >= sum_rb;

  // restoring division step
  assign trial  = {rem_r[31:0], dvd_r[16]};
  assign div_ge = trial >= {1'b0, mag_r};
  assign q_fin  = {quo_r[15:0], div_ge};
  assign q_rnd  = 16'((18'(q_fin) + 18'd1) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nst_r  <= N_IDLE;
      zero_r <= 1'b0;
      step_r <= '0;
      k_r    <= '0;
    end else begin
      unique case (nst_r)
        N_IDLE: begin
          if (req.start) begin
            m_r[0] <= abs_x;
            m_r[1] <= abs_y;
            m_r[2] <= abs_z;
            neg_r  <= {req.cz[CRS_W-1], req.cy[CRS_W-1], req.cx[CRS_W-1]};
            zero_r <= (req.cx == '0) && (req.cy == '0) && (req.cz == '0);
            step_r <= '0;
            nst_r  <= ((req.cx == '0) && (req.cy == '0) && (req.cz == '0)) ?
                      N_DONE : N_SHIFT;
          end
        end
        N_SHIFT: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (top[CRS_W-1:30] != '0) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (!top[29]) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            step_r <= '0;
            sq_r   <= '0;
            nst_r  <= N_SQ;
          end
        end
        N_SQ: begin
          if (step_r < 6'd3) prod_r <= m_r[step_r[1:0]][29:0] * m_r[step_r[1:0]][29:0];
          if (step_r != 6'd0) sq_r <= sq_r + 62'(prod_r);
          if (step_r == 6'd3) begin
            rad_r  <= sq_r + 62'(prod_r);
            root_r <= '0;
            bit_r  <= {1'b1, 62'd0};
            step_r <= '0;
            nst_r  <= N_SQRT;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        N_SQRT: begin
          if (sq_ge) begin
            rad_r  <= rad_r - sum_rb[61:0];
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (step_r == 6'd31) begin
            mag_r  <= sq_ge ? 32'((root_r >> 1) + bit_r) : 32'(root_r >> 1);
            k_r    <= '0;
            rem_r  <= 33'(m_r[0] >> 2);
            dvd_r  <= {m_r[0][1:0], 15'd0};
            quo_r  <= '0;
            step_r <= '0;
            nst_r  <= N_DIV;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        N_DIV: begin
          // last step of a component reloads the divider for the next one
          if ((step_r == 6'd16) && (k_r != 2'd2)) begin
            rem_r <= 33'(m_r[k_r + 2'd1] >> 2);
            dvd_r <= {m_r[k_r + 2'd1][1:0], 15'd0};
            quo_r <= '0;
          end else begin
            rem_r <= div_ge ? trial - {1'b0, mag_r} : trial;
            dvd_r <= dvd_r << 1;
            quo_r <= q_fin;
          end
          if (step_r == 6'd16) begin
            n_r[k_r] <= neg_r[k_r] ? -NQ_W'(signed'({1'b0, q_rnd[14:0]})) - 
                        NQ_W'(signed'({q_rnd[15], 15'd0})) :
                        signed'(q_rnd);
            step_r <= '0;
            if (k_r == 2'd2) begin
              nst_r <= N_DONE;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        N_DONE: begin
          nst_r <= N_IDLE;
        end
        default: nst_r <= N_IDLE;
      endcase
    end
  end

  assign stat.done = (nst_r == N_DONE);
  assign stat.zero = zero_r;
  assign n_x = n_r[0];
  assign n_y = n_r[1];
  assign n_z = n_r[2];

endmodule

>>> hw/rtl/quad_mesh_normal_accumulator_unit.sv
// quad_mesh_normal_accumulator_unit: top level with the vertex and sum memories
// depends on qmna_pkg, qmna_channels and qmna_normalize

// One request is in flight at a time, one result per request. After reset the
// sum memory is swept to zero, one entry a cycle; requests are held off
// meanwhile while configuration writes are taken. A face takes three vertex
// memory reads, six products on one multiplier, a range shift of one bit a
// cycle, three squares, a 32-step square root, three 17-step divisions, then
// four read-modify-write passes over the sum memory, a read and a write per
// corner; a degenerate face skips the normalizer steps and the passes. The
// result sits in an output register, so a new request is taken while it waits.

module quad_mesh_normal_accumulator_unit #(
  parameter int MAX_VERTICES = qmna_pkg::MAX_VERTICES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  qmna_in_if.sink   in_ch,
  qmna_out_if.source out_ch,
  qmna_cfg_if.sink  cfg_ch
);
  import qmna_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DISP  = 13'b0000000000100,
    S_VRD   = 13'b0000000001000,
    S_VCAP  = 13'b0000000010000,
    S_DIFF  = 13'b0000000100000,
    S_MUL   = 13'b0000001000000,
    S_NORM  = 13'b0000010000000,
    S_SRD   = 13'b0000100000000,
    S_SWR   = 13'b0001000000000,
    S_RRD   = 13'b0010000000000,
    S_RCAP  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  // memories: x in the low third, then y, then z
  logic [3*POS_W-1:0] vmem [MAX_VERTICES];
  logic [3*NRM_W-1:0] smem [MAX_VERTICES];
  logic [3*POS_W-1:0] vmem_q_r;
  logic [3*NRM_W-1:0] smem_q_r;

  state_t state_r, state_nxt;
  logic [AW-1:0]  clr_r;
  logic [IDX_W-1:0] vc_r;

  // latched request
  logic [REQ_W-1:0]        req_r;
  logic [IDX_W-1:0]        vidx_r;
  logic signed [POS_W-1:0] px_r, py_r, pz_r;
  logic [IDX_W-1:0]        cor_r [4];

  logic [1:0]              k_r;
  logic signed [POS_W-1:0] p_r  [3][3];
  logic signed [DIF_W-1:0] d1_r [3];
  logic signed [DIF_W-1:0] d2_r [3];
  logic [2:0]              step_r;
  logic signed [PRD_W-1:0] prod_r;
  logic signed [CRS_W-1:0] c_r  [3];
  logic                    start_r;
  logic                    sat_r;
  logic signed [NQ_W-1:0]  n_r  [3];

  // pending result and output register
  logic signed [NRM_W-1:0] res_x_r, res_y_r, res_z_r;
  logic [ST_W-1:0]         res_st_r;
  logic                    out_valid_r;
  logic signed [NRM_W-1:0] out_x_r, out_y_r, out_z_r;
  logic [ST_W-1:0]         out_st_r;

  norm_req_t               nreq;
  norm_stat_t              nstat;
  logic signed [NQ_W-1:0]  nx, ny, nz;

  logic                    in_fire, out_slot_free;
  logic                    vmem_we, vmem_re, smem_we, smem_re;
  logic [AW-1:0]           smem_waddr, smem_raddr;
  logic [3*NRM_W-1:0]      smem_wdata;
  logic                    req_ok, face_ok;
  logic signed [DIF_W-1:0] mul_a, mul_b;
  logic [NRM_W:0]          upd [3];   // saturation flag above the sum

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx,
                                  input logic [IDX_W-1:0] vc);
    idx_ok = (idx != '0) && (idx <= vc) && (32'(idx) <= 32'(MAX_VERTICES));
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    to_addr = AW'(idx - IDX_W'(1));
  endfunction

  // saturating add of a unit normal component into a 24-bit sum
  function automatic logic [NRM_W:0] sat_add(input logic signed [NRM_W-1:0] old,
                                             input logic signed [NQ_W-1:0] n);
    logic signed [NRM_W:0] s;
    s = (NRM_W+1)'(old) + (NRM_W+1)'(n);
    if (s[NRM_W] != s[NRM_W-1]) begin
      sat_add = {1'b1, s[NRM_W] ? {1'b1, {(NRM_W-1){1'b0}}} : {1'b0, {(NRM_W-1){1'b1}}}};
    end else begin
      sat_add = {1'b0, s[NRM_W-1:0]};
    end
  endfunction

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_slot_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.normal_x = out_x_r;
  assign out_ch.normal_y = out_y_r;
  assign out_ch.normal_z = out_z_r;
  assign out_ch.status   = out_st_r;

  assign req_ok  = idx_ok(vidx_r, vc_r);
  assign face_ok = idx_ok(cor_r[0], vc_r) && idx_ok(cor_r[1], vc_r) &&
                   idx_ok(cor_r[2], vc_r) && idx_ok(cor_r[3], vc_r);

  // memory controls
  assign vmem_we    = (state_r == S_DISP) && (req_r == REQ_WRITE) && req_ok;
  assign vmem_re    = (state_r == S_VRD);
  assign smem_re    = (state_r == S_SRD) || (state_r == S_RRD);
  assign smem_raddr = (state_r == S_SRD) ? to_addr(cor_r[k_r]) : to_addr(vidx_r);
  assign smem_we    = (state_r == S_CLEAR) || (state_r == S_SWR);
  assign smem_waddr = (state_r == S_CLEAR) ? clr_r : to_addr(cor_r[k_r]);

  for (genvar g = 0; g < 3; g++) begin : g_upd
    assign upd[g] = sat_add(smem_q_r[g*NRM_W +: NRM_W], n_r[g]);
  end

  assign smem_wdata = (state_r == S_CLEAR) ? '0 :
                      {upd[2][NRM_W-1:0], upd[1][NRM_W-1:0], upd[0][NRM_W-1:0]};

  always_ff @(posedge clk) begin
    if (vmem_we) vmem[to_addr(vidx_r)] <= {pz_r, py_r, px_r};
    if (vmem_re) vmem_q_r <= vmem[to_addr(cor_r[k_r])];
  end

  always_ff @(posedge clk) begin
    if (smem_we) smem[smem_waddr] <= smem_wdata;
    if (smem_re) smem_q_r <= smem[smem_raddr];
  end

  // cross product operands, one product per cycle
  always_comb begin
    case (step_r)
      3'd0:    begin mul_a = d1_r[1]; mul_b = d2_r[2]; end
      3'd1:    begin mul_a = d1_r[2]; mul_b = d2_r[1]; end
      3'd2:    begin mul_a = d1_r[2]; mul_b = d2_r[0]; end
      3'd3:    begin mul_a = d1_r[0]; mul_b = d2_r[2]; end
      3'd4:    begin mul_a = d1_r[0]; mul_b = d2_r[1]; end
      default: begin mul_a = d1_r[1]; mul_b = d2_r[0]; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == LAST_ADDR) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_DISP;
      S_DISP: begin
        case (req_r)
          REQ_FACE: state_nxt = face_ok ? S_VRD : S_OUT;
          REQ_READ: state_nxt = req_ok ? S_RRD : S_OUT;
          default:  state_nxt = S_OUT;
        endcase
      end
      S_VRD:   state_nxt = S_VCAP;
      S_VCAP:  state_nxt = (k_r == 2'd2) ? S_DIFF : S_VRD;
      S_DIFF:  state_nxt = S_MUL;
      S_MUL:   if (step_r == 3'd6) state_nxt = S_NORM;
      S_NORM:  if (nstat.done) state_nxt = nstat.zero ? S_OUT : S_SRD;
      S_SRD:   state_nxt = S_SWR;
      S_SWR:   state_nxt = (k_r == 2'd3) ? S_OUT : S_SRD;
      S_RRD:   state_nxt = S_RCAP;
      S_RCAP:  state_nxt = S_OUT;
      S_OUT:   if (out_slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      vc_r        <= VC_RESET;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
      k_r         <= '0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      start_r <= (state_r == S_MUL) && (step_r == 3'd6);
      if (cfg_ch.valid) vc_r <= cfg_ch.data;

      // load a new result or drop the one just taken
      if ((state_r == S_OUT) && out_slot_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLEAR: clr_r <= clr_r + AW'(1);
        S_IDLE: begin
          if (in_fire) begin
            req_r    <= in_ch.req_type;
            vidx_r   <= in_ch.vertex_index;
            px_r     <= in_ch.pos_x;
            py_r     <= in_ch.pos_y;
            pz_r     <= in_ch.pos_z;
            cor_r[0] <= in_ch.corner_a;
            cor_r[1] <= in_ch.corner_b;
            cor_r[2] <= in_ch.corner_c;
            cor_r[3] <= in_ch.corner_d;
          end
        end
        S_DISP: begin
          // bad index, unknown type and all vertex writes settle here
          res_x_r  <= '0;
          res_y_r  <= '0;
          res_z_r  <= '0;
          res_st_r <= ((req_r == REQ_WRITE) && req_ok) ? ST_OK : ST_BAD_IDX;
          k_r      <= '0;
        end
        S_VCAP: begin
          p_r[k_r][0] <= vmem_q_r[0 +: POS_W];
          p_r[k_r][1] <= vmem_q_r[POS_W +: POS_W];
          p_r[k_r][2] <= vmem_q_r[2*POS_W +: POS_W];
          k_r         <= k_r + 2'd1;
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            d1_r[i] <= DIF_W'(p_r[1][i]) - DIF_W'(p_r[2][i]);
            d2_r[i] <= DIF_W'(p_r[0][i]) - DIF_W'(p_r[1][i]);
          end
          step_r <= '0;
        end
        S_MUL: begin
          // product j lands in c[j/2]: even j starts it, odd j subtracts
          if (step_r != 3'd6) prod_r <= mul_a * mul_b;
          if (step_r != 3'd0) begin
            if (!step_r[0]) begin
              c_r[step_r[2:1] - 2'd1] <= c_r[step_r[2:1] - 2'd1] -
                                         CRS_W'(prod_r);
            end else begin
              c_r[step_r[2:1]] <= CRS_W'(prod_r);
            end
          end
          step_r <= step_r + 3'd1;
        end
        S_NORM: begin
          if (nstat.done) begin
            n_r[0]   <= nx;
            n_r[1]   <= ny;
            n_r[2]   <= nz;
            res_x_r  <= nstat.zero ? '0 : NRM_W'(nx);
            res_y_r  <= nstat.zero ? '0 : NRM_W'(ny);
            res_z_r  <= nstat.zero ? '0 : NRM_W'(nz);
            res_st_r <= ST_DEGEN;
            sat_r    <= 1'b0;
            k_r      <= '0;
          end
        end
        S_SRD: ;
        S_SWR: begin
          // repeated corners are safe: the write lands before the next read
          sat_r <= sat_r || upd[0][NRM_W] || upd[1][NRM_W] || upd[2][NRM_W];
          if (k_r == 2'd3) begin
            res_st_r <= (sat_r || upd[0][NRM_W] || upd[1][NRM_W] || upd[2][NRM_W]) ?
                        ST_SAT : ST_OK;
          end
          k_r <= k_r + 2'd1;
        end
        S_RRD: ;
        S_RCAP: begin
          res_x_r  <= smem_q_r[0 +: NRM_W];
          res_y_r  <= smem_q_r[NRM_W +: NRM_W];
          res_z_r  <= smem_q_r[2*NRM_W +: NRM_W];
          res_st_r <= ST_OK;
        end
        S_OUT: begin
          if (out_slot_free) begin
            out_x_r     <= res_x_r;
            out_y_r     <= res_y_r;
            out_z_r     <= res_z_r;
            out_st_r    <= res_st_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign nreq.start = start_r;
  assign nreq.cx    = c_r[0];
  assign nreq.cy    = c_r[1];
  assign nreq.cz    = c_r[2];

  qmna_normalize u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .stat  (nstat),
    .n_x   (nx),
    .n_y   (ny),
    .n_z   (nz)
  );

`ifndef ASSERT_OFF
  // a request is never taken while the previous one is still at work
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("request taken while busy");

  // bad index results carry zero normals
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_BAD_IDX) |->
      (out_ch.normal_x == '0 && out_ch.normal_y == '0 && out_ch.normal_z == '0))
    else $error("bad index result with nonzero normal");

  // the normalizer finishes only while a face waits on it
  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    nstat.done |-> state_r == S_NORM)
    else $error("normalizer done outside face processing");
`endif

endmodule
